[design/lfr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the LRU frame replacer.
// Used by lfr_ctl, lfr_dp and lru_frame_replacer_top; no dependencies.
package lfr_pkg;

  localparam int FRAME_W = 6;
  localparam int ACTION_W = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [ACTION_W-1:0] ACT_VICTIM = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PIN    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNPIN  = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;    // sweep one entry of the present-bit memory
    logic capture;  // latch an accepted word and launch memory reads
    logic exec;     // update the list and load the result register
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;  // last entry of the sweep is being written
  } dp_sts_t;

endpackage

[design/lfr_ctl.sv]
`timescale 1ns / 1ps
// Controller for the LRU frame replacer: clear sweep, accept, execute, result valid.
// Depends on lfr_pkg.
module lfr_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lfr_pkg::dp_sts_t  sts,
  output lfr_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.clear   = (state_r == ST_CLEAR);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.exec    = (state_r == ST_EXEC) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed word did not raise out_valid");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the word was executed");

  a_no_exec_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!cmd.capture && !cmd.exec))
    else $error("word handled during clear sweep");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.exec)
    else $error("result register overwritten while stalled");
`endif

endmodule

[design/lfr_dp.sv]
`timescale 1ns / 1ps
// Datapath for the LRU frame replacer: doubly linked list in next/prev memories
// indexed by frame, present-bit memory, head/tail/count and result register. Uses lfr_pkg.
module lfr_dp #(
  parameter int FRAMES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfr_pkg::ctl_cmd_t                 cmd,
  output lfr_pkg::dp_sts_t                  sts,
  input  logic [lfr_pkg::ACTION_W-1:0]      in_action,
  input  logic [lfr_pkg::FRAME_W-1:0]       in_frame,
  output logic                              out_victim_found,
  output logic [lfr_pkg::FRAME_W-1:0]       out_victim_frame,
  output logic [lfr_pkg::COUNT_OUT_W-1:0]   out_evictable_count
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic             pres_mem [FRAMES];
  logic [IDX_W-1:0] next_mem [FRAMES];
  logic [IDX_W-1:0] prev_mem [FRAMES];

  logic [IDX_W-1:0] clr_ctr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] head_nxt;
  logic [IDX_W-1:0] tail_r;
  logic [IDX_W-1:0] tail_nxt;

  logic [lfr_pkg::ACTION_W-1:0] act_r;
  logic             frame_ok_r;
  logic [IDX_W-1:0] idx_r;
  logic             pres_rd_r;
  logic [IDX_W-1:0] next_rd_r;
  logic [IDX_W-1:0] prev_rd_r;
  logic [IDX_W-1:0] rd_addr;

  logic             pres_we;
  logic [IDX_W-1:0] pres_wa;
  logic             pres_wd;
  logic             next_we;
  logic [IDX_W-1:0] next_wa;
  logic [IDX_W-1:0] next_wd;
  logic             prev_we;
  logic [IDX_W-1:0] prev_wa;
  logic [IDX_W-1:0] prev_wd;

  logic             found_nxt;
  logic [IDX_W-1:0] vframe_nxt;

  logic                              victim_found_r;
  logic [lfr_pkg::FRAME_W-1:0]       victim_frame_r;
  logic [lfr_pkg::COUNT_OUT_W-1:0]   evictable_count_r;

  assign sts.clear_done = cmd.clear && (clr_ctr_r == IDX_W'(FRAMES - 1));

  // victim reads the tail node, pin and unpin read the named frame
  assign rd_addr = (in_action == lfr_pkg::ACT_VICTIM) ? tail_r : IDX_W'(in_frame);

  always_comb begin
    pres_we    = 1'b0;
    pres_wa    = idx_r;
    pres_wd    = 1'b0;
    next_we    = 1'b0;
    next_wa    = prev_rd_r;
    next_wd    = next_rd_r;
    prev_we    = 1'b0;
    prev_wa    = next_rd_r;
    prev_wd    = prev_rd_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    found_nxt  = 1'b0;
    vframe_nxt = '0;
    if (cmd.clear) begin
      pres_we = 1'b1;
      pres_wa = clr_ctr_r;
    end else if (cmd.exec) begin
      case (act_r)
        lfr_pkg::ACT_VICTIM: begin
          if (count_r != '0) begin
            pres_we    = 1'b1;
            found_nxt  = 1'b1;
            vframe_nxt = idx_r;
            tail_nxt   = prev_rd_r;
            count_nxt  = count_r - 1'b1;
          end
        end
        lfr_pkg::ACT_PIN: begin
          if (frame_ok_r && pres_rd_r) begin
            pres_we   = 1'b1;
            count_nxt = count_r - 1'b1;
            // unlink: bypass from the neighbors, or move head/tail
            if (idx_r == head_r) head_nxt = next_rd_r;
            else next_we = 1'b1;
            if (idx_r == tail_r) tail_nxt = prev_rd_r;
            else prev_we = 1'b1;
          end
        end
        lfr_pkg::ACT_UNPIN: begin
          if (frame_ok_r && !pres_rd_r) begin
            pres_we   = 1'b1;
            pres_wd   = 1'b1;
            next_we   = 1'b1;
            next_wa   = idx_r;
            next_wd   = head_r;
            prev_wa   = head_r;
            prev_wd   = idx_r;
            head_nxt  = idx_r;
            count_nxt = count_r + 1'b1;
            if (count_r != '0) prev_we = 1'b1;
            else tail_nxt = idx_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.capture) begin
      pres_rd_r <= pres_mem[rd_addr];
      next_rd_r <= next_mem[rd_addr];
      prev_rd_r <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= in_action;
      frame_ok_r <= (32'(in_frame) < FRAMES);
      idx_r      <= rd_addr;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (cmd.exec) begin
      victim_found_r    <= found_nxt;
      victim_frame_r    <= lfr_pkg::FRAME_W'(vframe_nxt);
      evictable_count_r <= lfr_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ctr_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.clear) clr_ctr_r <= clr_ctr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign out_victim_found    = victim_found_r;
  assign out_victim_frame    = victim_frame_r;
  assign out_evictable_count = evictable_count_r;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= FRAMES)
    else $error("evictable count beyond frame count");

  a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> (count_r == $past(count_r)))
    else $error("count changed without an executed word");

  a_victim_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && found_nxt) |-> (count_r != '0))
    else $error("victim reported from empty list");
`endif

endmodule

[design/lru_frame_replacer_top.sv]
`timescale 1ns / 1ps
// Top level of the LRU frame replacer with pinning.
// Instantiates lfr_ctl and lfr_dp; uses lfr_pkg.
//
//   channel | ports                                                      | dir
//   --------+------------------------------------------------------------+-----
//   input   | in_valid, in_stall, in_action, in_frame                    | in
//   result  | out_valid, out_stall, out_victim_found, out_victim_frame,  | out
//           | out_evictable_count                                        |
//
// Each word is handled as an accept with memory read, then a list update and
// result load; the single read/write port of the next/prev/present memories
// keeps them apart; in_stall stays high until the update is done. A stalled
// result holds the update step until the register frees. After reset a pass
// over all FRAMES entries zeroes the present bits, in_stall high throughout.
module lru_frame_replacer_top #(
  parameter int FRAMES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lfr_pkg::ACTION_W-1:0]    in_action,
  input  logic [lfr_pkg::FRAME_W-1:0]     in_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_victim_found,
  output logic [lfr_pkg::FRAME_W-1:0]     out_victim_frame,
  output logic [lfr_pkg::COUNT_OUT_W-1:0] out_evictable_count
);

  lfr_pkg::ctl_cmd_t cmd;
  lfr_pkg::dp_sts_t  sts;

  lfr_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfr_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_frame            (in_frame),
    .out_victim_found    (out_victim_found),
    .out_victim_frame    (out_victim_frame),
    .out_evictable_count (out_evictable_count)
  );

endmodule
